// ===== rtl/mse_pkg.sv =====
package mse_pkg;

	localparam int XLEN      = 32;
	localparam int REG_COUNT = 32;
	localparam int REG_AW    = $clog2(REG_COUNT);
	localparam int IDX_W     = 5;
	localparam int OP_W      = 5;
	localparam int CNT_W     = $clog2(XLEN);

	typedef enum logic [OP_W-1:0] {
		OP_LI    = 5'd0,
		OP_ADD   = 5'd1,
		OP_SUB   = 5'd2,
		OP_ADDI  = 5'd3,
		OP_ADDU  = 5'd4,
		OP_SUBU  = 5'd5,
		OP_ADDIU = 5'd6,
		OP_MUL   = 5'd7,
		OP_MULT  = 5'd8,
		OP_DIV   = 5'd9,
		OP_AND   = 5'd10,
		OP_OR    = 5'd11,
		OP_ANDI  = 5'd12,
		OP_ORI   = 5'd13,
		OP_SLL   = 5'd14,
		OP_SRL   = 5'd15,
		OP_XOR   = 5'd16
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_COMMIT
	} state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_RUN,
		MD_FIX
	} md_state_t;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [IDX_W-1:0]        dest_reg;
		logic [IDX_W-1:0]        src_a;
		logic [IDX_W-1:0]        src_b;
		logic signed [XLEN-1:0]  immediate;
	} instr_t;

	typedef struct packed {
		logic                    wrote_reg;
		logic [IDX_W-1:0]        written_index;
		logic signed [XLEN-1:0]  written_value;
		logic signed [XLEN-1:0]  hi_value;
		logic signed [XLEN-1:0]  lo_value;
		logic                    divide_by_zero;
	} result_t;

	typedef struct packed {
		logic            start;
		logic            is_div;
		logic [XLEN-1:0] x;
		logic [XLEN-1:0] y;
	} md_req_t;

	typedef struct packed {
		logic            done;
		logic [XLEN-1:0] hi;
		logic [XLEN-1:0] lo;
	} md_rsp_t;

endpackage

// ===== rtl/mse_regfile.sv =====
module mse_regfile (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [mse_pkg::REG_AW-1:0]    rd_idx0,
	input  logic [mse_pkg::REG_AW-1:0]    rd_idx1,
	output logic [mse_pkg::XLEN-1:0]      rd_data0,
	output logic [mse_pkg::XLEN-1:0]      rd_data1,
	input  logic                          wr_en,
	input  logic [mse_pkg::REG_AW-1:0]    wr_idx,
	input  logic [mse_pkg::XLEN-1:0]      wr_data
);

	logic [mse_pkg::XLEN-1:0]      mem [mse_pkg::REG_COUNT];
	logic [mse_pkg::XLEN-1:0]      rd0_q;
	logic [mse_pkg::XLEN-1:0]      rd1_q;
	logic                          v0_q;
	logic                          v1_q;
	logic [mse_pkg::REG_COUNT-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd0_q <= mem[rd_idx0];
			rd1_q <= mem[rd_idx1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			v0_q  <= 1'b0;
			v1_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				v0_q <= vld_q[rd_idx0];
				v1_q <= vld_q[rd_idx1];
			end
		end
	end

	assign rd_data0 = v0_q ? rd0_q : '0;
	assign rd_data1 = v1_q ? rd1_q : '0;

endmodule

// ===== rtl/mse_muldiv.sv =====
module mse_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  mse_pkg::md_req_t req,
	output mse_pkg::md_rsp_t rsp
);

	mse_pkg::md_state_t state_q;
	mse_pkg::md_state_t state_n;

	logic [mse_pkg::XLEN-1:0]  acc_q;
	logic [mse_pkg::XLEN-1:0]  lo_q;
	logic [mse_pkg::XLEN-1:0]  opnd_q;
	logic [mse_pkg::CNT_W-1:0] cnt_q;
	logic                      is_div_q;
	logic                      neg_q_q;
	logic                      neg_r_q;

	logic [mse_pkg::XLEN-1:0]   mx;
	logic [mse_pkg::XLEN-1:0]   my;
	logic [mse_pkg::XLEN:0]     sum;
	logic [mse_pkg::XLEN:0]     trial;
	logic [mse_pkg::XLEN-1:0]   acc_n;
	logic [mse_pkg::XLEN-1:0]   lo_n;
	logic [2*mse_pkg::XLEN-1:0] prod;
	logic [2*mse_pkg::XLEN-1:0] prod_f;
	logic                       last;

	assign mx = req.x[mse_pkg::XLEN-1] ? (~req.x + 1'b1) : req.x;
	assign my = req.y[mse_pkg::XLEN-1] ? (~req.y + 1'b1) : req.y;
	assign last = (cnt_q == {mse_pkg::CNT_W{1'b1}});

	always_comb begin
		sum   = {1'b0, acc_q} + (lo_q[0] ? {1'b0, opnd_q} : '0);
		trial = {acc_q, lo_q[mse_pkg::XLEN-1]} - {1'b0, opnd_q};
		if (is_div_q) begin
			if (!trial[mse_pkg::XLEN]) begin
				acc_n = trial[mse_pkg::XLEN-1:0];
				lo_n  = {lo_q[mse_pkg::XLEN-2:0], 1'b1};
			end else begin
				acc_n = {acc_q[mse_pkg::XLEN-2:0], lo_q[mse_pkg::XLEN-1]};
				lo_n  = {lo_q[mse_pkg::XLEN-2:0], 1'b0};
			end
		end else begin
			acc_n = sum[mse_pkg::XLEN:1];
			lo_n  = {sum[0], lo_q[mse_pkg::XLEN-1:1]};
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			mse_pkg::MD_IDLE: begin
				if (req.start) begin
					state_n = mse_pkg::MD_RUN;
				end
			end
			mse_pkg::MD_RUN: begin
				if (last) begin
					state_n = mse_pkg::MD_FIX;
				end
			end
			mse_pkg::MD_FIX: state_n = mse_pkg::MD_IDLE;
			default:         state_n = mse_pkg::MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mse_pkg::MD_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == mse_pkg::MD_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mse_pkg::MD_IDLE && req.start) begin
			acc_q    <= '0;
			lo_q     <= req.is_div ? mx : my;
			opnd_q   <= req.is_div ? my : mx;
			is_div_q <= req.is_div;
			neg_q_q  <= req.x[mse_pkg::XLEN-1] ^ req.y[mse_pkg::XLEN-1];
			neg_r_q  <= req.x[mse_pkg::XLEN-1];
		end else if (state_q == mse_pkg::MD_RUN) begin
			acc_q <= acc_n;
			lo_q  <= lo_n;
		end
	end

	assign prod   = {acc_q, lo_q};
	assign prod_f = neg_q_q ? (~prod + 1'b1) : prod;

	always_comb begin
		rsp.done = (state_q == mse_pkg::MD_FIX);
		if (is_div_q) begin
			rsp.hi = neg_r_q ? (~acc_q + 1'b1) : acc_q;
			rsp.lo = neg_q_q ? (~lo_q + 1'b1) : lo_q;
		end else begin
			rsp.hi = prod_f[2*mse_pkg::XLEN-1:mse_pkg::XLEN];
			rsp.lo = prod_f[mse_pkg::XLEN-1:0];
		end
	end

endmodule

// ===== rtl/mips_subset_execute_unit_top.sv =====
// Accepted operands are read from the register file into registers; li, logic, add/sub,
// shifts and divide by zero then pass from ST_READ to ST_COMMIT, which registers the
// result and raises result_valid; mul, mult and div pass through ST_CALC, where the
// shared shift-add/restoring unit runs one bit per cycle. Only one instruction is in
// flight; a stalled result holds the input for as long as the stall lasts.
// Reset clears every register (per-entry valid bits in the file) and hi/lo at once.
module mips_subset_execute_unit_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             instr_valid,
	output logic             instr_stall,
	input  mse_pkg::instr_t  instr,
	output logic             result_valid,
	input  logic             result_stall,
	output mse_pkg::result_t result
);

	mse_pkg::state_t  state_q;
	mse_pkg::state_t  state_n;
	mse_pkg::instr_t  inst_q;
	mse_pkg::result_t result_q;
	mse_pkg::md_req_t md_req;
	mse_pkg::md_rsp_t md_rsp;

	logic [mse_pkg::XLEN-1:0] hi_q;
	logic [mse_pkg::XLEN-1:0] lo_q;
	logic [mse_pkg::XLEN-1:0] nhi_q;
	logic [mse_pkg::XLEN-1:0] nlo_q;
	logic [mse_pkg::XLEN-1:0] res_q;
	logic                     wr_q;
	logic                     dz_q;
	logic                     ina_q;
	logic                     inb_q;
	logic                     result_valid_q;

	logic                       accept;
	logic                       is_md_in;
	logic [mse_pkg::IDX_W-1:0]  idx0;
	logic [mse_pkg::IDX_W-1:0]  idx1;
	logic [mse_pkg::XLEN-1:0]   rd0;
	logic [mse_pkg::XLEN-1:0]   rd1;
	logic [mse_pkg::XLEN-1:0]   va;
	logic [mse_pkg::XLEN-1:0]   vb;
	logic [mse_pkg::XLEN-1:0]   imm;
	logic [mse_pkg::XLEN-1:0]   alu_res;
	logic                       alu_wr;
	logic                       md_go;
	logic                       dz;
	logic                       dest_ok;
	logic                       commit;
	logic                       rf_wr;

	assign accept   = instr_valid && !instr_stall;
	assign is_md_in = (instr.op == mse_pkg::OP_MULT) || (instr.op == mse_pkg::OP_DIV);
	assign idx0     = is_md_in ? instr.dest_reg : instr.src_a;
	assign idx1     = is_md_in ? instr.src_a : instr.src_b;

	mse_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_idx0  (mse_pkg::REG_AW'(idx0)),
		.rd_idx1  (mse_pkg::REG_AW'(idx1)),
		.rd_data0 (rd0),
		.rd_data1 (rd1),
		.wr_en    (rf_wr),
		.wr_idx   (mse_pkg::REG_AW'(inst_q.dest_reg)),
		.wr_data  (res_q)
	);

	mse_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	assign va      = ina_q ? rd0 : '0;
	assign vb      = inb_q ? rd1 : '0;
	assign imm     = inst_q.immediate;
	assign dest_ok = (32'(inst_q.dest_reg) < mse_pkg::REG_COUNT);

	always_comb begin
		alu_res = '0;
		alu_wr  = 1'b1;
		md_go   = 1'b0;
		dz      = 1'b0;
		case (mse_pkg::op_t'(inst_q.op))
			mse_pkg::OP_LI:    alu_res = imm;
			mse_pkg::OP_ADD,
			mse_pkg::OP_ADDU:  alu_res = va + vb;
			mse_pkg::OP_SUB,
			mse_pkg::OP_SUBU:  alu_res = va - vb;
			mse_pkg::OP_ADDI,
			mse_pkg::OP_ADDIU: alu_res = va + imm;
			mse_pkg::OP_MUL: begin
				md_go  = 1'b1;
			end
			mse_pkg::OP_MULT: begin
				alu_wr = 1'b0;
				md_go  = 1'b1;
			end
			mse_pkg::OP_DIV: begin
				alu_wr = 1'b0;
				if (vb == '0) begin
					dz    = 1'b1;
				end else begin
					md_go = 1'b1;
				end
			end
			mse_pkg::OP_AND:   alu_res = va & vb;
			mse_pkg::OP_OR:    alu_res = va | vb;
			mse_pkg::OP_ANDI:  alu_res = va & imm;
			mse_pkg::OP_ORI:   alu_res = va | imm;
			mse_pkg::OP_SLL:   alu_res = va << imm[4:0];
			mse_pkg::OP_SRL:   alu_res = va >> imm[4:0];
			mse_pkg::OP_XOR:   alu_res = va ^ vb;
			default:           alu_wr  = 1'b0;
		endcase
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			mse_pkg::ST_IDLE: begin
				if (instr_valid) begin
					state_n = mse_pkg::ST_READ;
				end
			end
			mse_pkg::ST_READ: begin
				state_n = md_go ? mse_pkg::ST_CALC : mse_pkg::ST_COMMIT;
			end
			mse_pkg::ST_CALC: begin
				if (md_rsp.done) begin
					state_n = mse_pkg::ST_COMMIT;
				end
			end
			mse_pkg::ST_COMMIT: begin
				if (commit) begin
					state_n = mse_pkg::ST_IDLE;
				end
			end
			default: state_n = mse_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		instr_stall   = (state_q != mse_pkg::ST_IDLE);
		md_req.start  = (state_q == mse_pkg::ST_READ) && md_go;
		md_req.is_div = (inst_q.op == mse_pkg::OP_DIV);
		md_req.x      = (inst_q.op == mse_pkg::OP_MUL) ? va : va;
		md_req.y      = vb;
		commit        = (state_q == mse_pkg::ST_COMMIT) && (!result_valid_q || !result_stall);
		rf_wr         = commit && wr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= mse_pkg::ST_IDLE;
			hi_q           <= '0;
			lo_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (commit) begin
				hi_q           <= nhi_q;
				lo_q           <= nlo_q;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inst_q <= instr;
			ina_q  <= (32'(idx0) < mse_pkg::REG_COUNT);
			inb_q  <= (32'(idx1) < mse_pkg::REG_COUNT);
		end
		if (state_q == mse_pkg::ST_READ) begin
			res_q <= alu_res;
			wr_q  <= alu_wr && dest_ok;
			dz_q  <= dz;
			nhi_q <= hi_q;
			nlo_q <= lo_q;
		end
		if (state_q == mse_pkg::ST_CALC && md_rsp.done) begin
			if (inst_q.op == mse_pkg::OP_MUL) begin
				res_q <= md_rsp.lo;
			end else begin
				nhi_q <= md_rsp.hi;
				nlo_q <= md_rsp.lo;
			end
		end
		if (commit) begin
			result_q.wrote_reg      <= wr_q;
			result_q.written_index  <= wr_q ? inst_q.dest_reg : '0;
			result_q.written_value  <= wr_q ? res_q : '0;
			result_q.hi_value       <= nhi_q;
			result_q.lo_value       <= nlo_q;
			result_q.divide_by_zero <= dz_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== verif/mips_subset_execute_unit_top_tb.sv =====
module mips_subset_execute_unit_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [mse_pkg::OP_W-1:0] OP_UNUSED_FIRST = 5'd17;
	localparam logic [mse_pkg::OP_W-1:0] OP_UNUSED_LAST  = 5'd31;
	localparam logic [mse_pkg::XLEN-1:0] WORD_MIN  = 32'h8000_0000;
	localparam logic [mse_pkg::XLEN-1:0] WORD_MAX  = 32'h7fff_ffff;
	localparam logic [mse_pkg::XLEN-1:0] WORD_ONES = 32'hffff_ffff;
	localparam int MAX_IDLE   = 12;
	localparam int LONG_HOLD  = 250;
	localparam int DRAIN_WAIT = 60;

	class exec_scoreboard;
		logic [mse_pkg::XLEN-1:0] gpr [mse_pkg::REG_COUNT];
		logic [mse_pkg::XLEN-1:0] hi_q;
		logic [mse_pkg::XLEN-1:0] lo_q;
		mse_pkg::result_t expected_results[$];
		int errors;
		int executed;
		int compared;
		int div_zero_seen;
		int unknown_seen;

		function new();
			foreach (gpr[i])
				gpr[i] = '0;
			hi_q = '0;
			lo_q = '0;
			errors = 0;
			executed = 0;
			compared = 0;
			div_zero_seen = 0;
			unknown_seen = 0;
		endfunction

		function logic [mse_pkg::XLEN-1:0] read_gpr(logic [mse_pkg::IDX_W-1:0] idx);
			return (idx < mse_pkg::REG_COUNT) ? gpr[idx] : '0;
		endfunction

		function mse_pkg::result_t execute_instr(mse_pkg::instr_t it);
			mse_pkg::result_t r;
			logic [mse_pkg::XLEN-1:0] va, vb, vd, imm, res, mx, my, quo, rem;
			logic [2*mse_pkg::XLEN-1:0] prod;
			bit wr, dz;
			va = read_gpr(it.src_a);
			vb = read_gpr(it.src_b);
			vd = read_gpr(it.dest_reg);
			imm = it.immediate;
			res = '0;
			wr = 1'b1;
			dz = 1'b0;
			case (it.op)
				mse_pkg::OP_LI: res = imm;
				mse_pkg::OP_ADD, mse_pkg::OP_ADDU: res = va + vb;
				mse_pkg::OP_SUB, mse_pkg::OP_SUBU: res = va - vb;
				mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: res = va + imm;
				mse_pkg::OP_MUL: res = va * vb;
				mse_pkg::OP_MULT: begin
					prod = {{mse_pkg::XLEN{vd[mse_pkg::XLEN-1]}}, vd}
						* {{mse_pkg::XLEN{va[mse_pkg::XLEN-1]}}, va};
					hi_q = prod[2*mse_pkg::XLEN-1:mse_pkg::XLEN];
					lo_q = prod[mse_pkg::XLEN-1:0];
					wr = 1'b0;
				end
				mse_pkg::OP_DIV: begin
					wr = 1'b0;
					if (va == '0) begin
						dz = 1'b1;
					end else begin
						mx = vd[mse_pkg::XLEN-1] ? (32'd0 - vd) : vd;
						my = va[mse_pkg::XLEN-1] ? (32'd0 - va) : va;
						quo = mx / my;
						rem = mx % my;
						if (vd[mse_pkg::XLEN-1] != va[mse_pkg::XLEN-1])
							quo = 32'd0 - quo;
						if (vd[mse_pkg::XLEN-1])
							rem = 32'd0 - rem;
						lo_q = quo;
						hi_q = rem;
					end
				end
				mse_pkg::OP_AND: res = va & vb;
				mse_pkg::OP_OR: res = va | vb;
				mse_pkg::OP_ANDI: res = va & imm;
				mse_pkg::OP_ORI: res = va | imm;
				mse_pkg::OP_SLL: res = va << imm[4:0];
				mse_pkg::OP_SRL: res = va >> imm[4:0];
				mse_pkg::OP_XOR: res = va ^ vb;
				default: begin
					wr = 1'b0;
					unknown_seen++;
				end
			endcase
			if (wr && it.dest_reg >= mse_pkg::REG_COUNT)
				wr = 1'b0;
			if (wr)
				gpr[it.dest_reg] = res;
			if (dz)
				div_zero_seen++;
			r.wrote_reg = wr;
			r.written_index = wr ? it.dest_reg : '0;
			r.written_value = wr ? res : '0;
			r.hi_value = hi_q;
			r.lo_value = lo_q;
			r.divide_by_zero = dz;
			return r;
		endfunction

		function void note_instr(mse_pkg::instr_t it);
			expected_results = {expected_results, execute_instr(it)};
			executed++;
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction

		task report(string what, logic [mse_pkg::XLEN-1:0] got,
				logic [mse_pkg::XLEN-1:0] want);
			$display("result %0d: %s got 0x%08h, expected 0x%08h", compared, what, got, want);
			errors++;
		endtask

		task check_result(mse_pkg::result_t got);
			mse_pkg::result_t want;
			if (expected_results.size() == 0) begin
				report("unexpected item", got.written_value, '0);
				return;
			end
			want = expected_results.pop_front();
			if (got.wrote_reg !== want.wrote_reg)
				report("wrote_reg", 32'(got.wrote_reg), 32'(want.wrote_reg));
			if (got.written_index !== want.written_index)
				report("written_index", 32'(got.written_index), 32'(want.written_index));
			if (got.written_value !== want.written_value)
				report("written_value", got.written_value, want.written_value);
			if (got.hi_value !== want.hi_value)
				report("hi_value", got.hi_value, want.hi_value);
			if (got.lo_value !== want.lo_value)
				report("lo_value", got.lo_value, want.lo_value);
			if (got.divide_by_zero !== want.divide_by_zero)
				report("divide_by_zero", 32'(got.divide_by_zero), 32'(want.divide_by_zero));
			compared++;
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             instr_valid;
	logic             instr_stall;
	mse_pkg::instr_t  instr;
	logic             result_valid;
	logic             result_stall;
	mse_pkg::result_t result;

	exec_scoreboard sb;
	bit no_idle;
	int hold_cycles;
	int long_holds;

	mips_subset_execute_unit_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_stall  (instr_stall),
		.instr        (instr),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (instr_valid && !instr_stall)
				sb.note_instr(instr);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	function automatic mse_pkg::instr_t make_instr(logic [mse_pkg::OP_W-1:0] op, int d,
			int a, int b, logic [mse_pkg::XLEN-1:0] imm);
		mse_pkg::instr_t it;
		it.op = op;
		it.dest_reg = mse_pkg::IDX_W'(d);
		it.src_a = mse_pkg::IDX_W'(a);
		it.src_b = mse_pkg::IDX_W'(b);
		it.immediate = imm;
		return it;
	endfunction

	function automatic logic [mse_pkg::IDX_W-1:0] pick_reg(bit near);
		return near ? mse_pkg::IDX_W'($urandom_range(0, 7))
			: mse_pkg::IDX_W'($urandom_range(0, 31));
	endfunction

	function automatic mse_pkg::instr_t random_instr();
		mse_pkg::instr_t it;
		int pick;
		bit near;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			it.op = mse_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		else if (pick < 22)
			it.op = mse_pkg::OP_LI;
		else
			it.op = mse_pkg::OP_W'($urandom_range(mse_pkg::OP_LI, mse_pkg::OP_XOR));
		near = 1'($urandom_range(0, 1));
		it.dest_reg = pick_reg(near);
		it.src_a = pick_reg(near);
		it.src_b = pick_reg(near);
		case ($urandom_range(0, 3))
			0: it.immediate = $urandom_range(0, 64) - 32;
			1: begin
				case ($urandom_range(0, 3))
					0: it.immediate = WORD_MIN;
					1: it.immediate = WORD_MAX;
					2: it.immediate = WORD_ONES;
					default: it.immediate = '0;
				endcase
			end
			default: it.immediate = $urandom;
		endcase
		return it;
	endfunction

	task automatic send(mse_pkg::instr_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
		@(negedge clk);
		if (gap > 0) begin
			instr_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		instr <= it;
		instr_valid <= 1'b1;
		do @(posedge clk); while (instr_stall);
	endtask

	initial begin
		int stall_n;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			stall_n = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
			if (hold_cycles > 0) begin
				stall_n += hold_cycles;
				hold_cycles = 0;
				long_holds++;
			end
			@(negedge clk);
			if (stall_n > 0) begin
				result_stall <= 1'b1;
				repeat (stall_n) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin
		#5_000_000;
		$display("timeout");
		$display("mips_subset_execute_unit_top: mismatch");
		$finish;
	end

	initial begin
		sb = new();
		no_idle = 1'b0;
		hold_cycles = 0;
		long_holds = 0;
		arst_n = 1'b0;
		instr_valid = 1'b0;
		instr = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		send(make_instr(mse_pkg::OP_LI, 1, 0, 0, WORD_MAX));
		send(make_instr(mse_pkg::OP_LI, 2, 0, 0, WORD_MIN));
		send(make_instr(mse_pkg::OP_LI, 3, 0, 0, WORD_ONES));
		send(make_instr(mse_pkg::OP_LI, 0, 0, 0, 32'h1234_5678));
		send(make_instr(mse_pkg::OP_ADD, 5, 1, 1, '0));
		send(make_instr(mse_pkg::OP_SUB, 6, 2, 1, '0));
		send(make_instr(mse_pkg::OP_ADDI, 7, 1, 0, 32'd1));
		send(make_instr(mse_pkg::OP_ADDU, 8, 3, 3, '0));
		send(make_instr(mse_pkg::OP_SUBU, 9, 4, 2, '0));
		send(make_instr(mse_pkg::OP_ADDIU, 10, 3, 0, WORD_MIN));
		send(make_instr(mse_pkg::OP_MUL, 11, 1, 3, '0));
		send(make_instr(mse_pkg::OP_MULT, 2, 3, 0, '0));
		send(make_instr(mse_pkg::OP_MULT, 1, 1, 0, '0));
		send(make_instr(mse_pkg::OP_DIV, 2, 3, 0, '0));
		send(make_instr(mse_pkg::OP_DIV, 1, 4, 0, '0));
		send(make_instr(mse_pkg::OP_LI, 12, 0, 0, 32'hffff_fff9));
		send(make_instr(mse_pkg::OP_LI, 13, 0, 0, 32'd2));
		send(make_instr(mse_pkg::OP_DIV, 12, 13, 0, '0));
		send(make_instr(mse_pkg::OP_AND, 14, 0, 3, '0));
		send(make_instr(mse_pkg::OP_OR, 15, 2, 0, '0));
		send(make_instr(mse_pkg::OP_ANDI, 16, 3, 0, 32'h0000_ffff));
		send(make_instr(mse_pkg::OP_ORI, 17, 4, 0, WORD_MIN));
		send(make_instr(mse_pkg::OP_SLL, 18, 3, 0, 32'hffff_ffe1));
		send(make_instr(mse_pkg::OP_SLL, 19, 0, 0, 32'd31));
		send(make_instr(mse_pkg::OP_SRL, 20, 2, 0, 32'd31));
		send(make_instr(mse_pkg::OP_SRL, 21, 3, 0, '0));
		send(make_instr(mse_pkg::OP_XOR, 22, 1, 3, '0));
		send(make_instr(OP_UNUSED_FIRST, 1, 2, 3, WORD_ONES));
		send(make_instr(OP_UNUSED_LAST, 1, 2, 3, WORD_ONES));

		for (int seg = 0; seg < 6; seg++) begin
			no_idle = (seg % 2) == 1;
			if (seg == 2)
				hold_cycles = LONG_HOLD;
			repeat (100) send(random_instr());
		end
		no_idle = 1'b0;

		@(negedge clk);
		instr_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("%0d instructions executed, %0d results compared, %0d long output holds",
			sb.executed, sb.compared, long_holds);
		$display("%0d divides by zero, %0d unused opcodes, %0d field errors",
			sb.div_zero_seen, sb.unknown_seen, sb.errors);
		if (sb.errors == 0)
			$display("mips_subset_execute_unit_top: match");
		else
			$display("mips_subset_execute_unit_top: mismatch");
		$finish;
	end

endmodule
